>>> src/wls_pkg.sv
// ----------------------------------------------------------------------------
// wls_pkg
// Shared widths, codes and defaults for the windowed level statistics block.
// ----------------------------------------------------------------------------
package wls_pkg;

	localparam int LEVEL_W     = 16;
	localparam int STAMP_W     = 32;
	localparam int LIMIT_W     = 7;
	localparam int COUNT_OUT_W = 7;
	localparam int TREND_W     = 2;

	localparam int STORE_DEPTH_DEF = 64;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// trend fires when newest minus oldest of the last three passes this
	localparam int TREND_THRESHOLD = 100;
	localparam int TREND_MIN_COUNT = 3;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic signed [TREND_W-1:0] TREND_FLAT = 2'sb00;
	localparam logic signed [TREND_W-1:0] TREND_UP   = 2'sb01;
	localparam logic signed [TREND_W-1:0] TREND_DOWN = 2'sb11;

endpackage

>>> src/wls_store.sv
// ----------------------------------------------------------------------------
// wls_store
// Sample ring memories: level and stamp, one write and one registered read.
// ----------------------------------------------------------------------------
module wls_store
	import wls_pkg::*;
#(
	parameter int DEPTH = STORE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [LEVEL_W-1:0] wr_level,
	input  logic [STAMP_W-1:0] wr_stamp,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [LEVEL_W-1:0] rd_level,
	output logic [STAMP_W-1:0] rd_stamp
);

	logic [LEVEL_W-1:0] level_mem [DEPTH];
	logic [STAMP_W-1:0] stamp_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			level_mem[wr_addr] <= wr_level;
			stamp_mem[wr_addr] <= wr_stamp;
		end
		if (rd_en) begin
			rd_level <= level_mem[rd_addr];
			rd_stamp <= stamp_mem[rd_addr];
		end
	end

endmodule

>>> src/wls_div.sv
// ----------------------------------------------------------------------------
// wls_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wls_div
	import wls_pkg::*;
#(
	parameter int NW = LEVEL_W + 7,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] denom,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> src/windowed_level_statistics_top.sv
// ----------------------------------------------------------------------------
// windowed_level_statistics_top
// Sliding window of level samples with count, min, max, mean, span and trend.
// ----------------------------------------------------------------------------
// Flow: a transaction walks the held samples through the memory read port,
//   then the serial mean divider runs before the result is registered; an
//   empty window skips the walk and the divider.
// Throughput: one transaction at a time; the next can be taken the cycle after
//   the result is in the output register.
//   Memory contents need no clearing after reset.
// Reset: arst_n clears the window, the ring pointer and sets the limit to 64.
// ----------------------------------------------------------------------------
module windowed_level_statistics_top
	import wls_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [LIMIT_W-1:0]        window_limit,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [LEVEL_W-1:0]        level,
	input  logic [STAMP_W-1:0]        stamp,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COUNT_OUT_W-1:0]    sample_count,
	output logic [LEVEL_W-1:0]        level_min,
	output logic [LEVEL_W-1:0]        level_max,
	output logic [LEVEL_W-1:0]        level_mean,
	output logic [STAMP_W-1:0]        span,
	output logic signed [TREND_W-1:0] trend
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int MW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int SW = LEVEL_W + CW;
	localparam logic [MW-1:0] DEPTH_M = MW'(STORE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);
	localparam logic signed [LEVEL_W:0] THR_P = (LEVEL_W+1)'(TREND_THRESHOLD);
	localparam logic signed [LEVEL_W:0] THR_N = -(LEVEL_W+1)'(TREND_THRESHOLD);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [LIMIT_W-1:0] limit_q;
	logic [AW-1:0]      newest_q;
	logic [CW-1:0]      held_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      rd_addr_q;
	logic               rd_vld_s1;
	logic [CW-1:0]      idx_s1;

	logic [LEVEL_W-1:0] min_q;
	logic [LEVEL_W-1:0] max_q;
	logic [SW-1:0]      sum_q;
	logic [LEVEL_W-1:0] lvl_new_q;
	logic [LEVEL_W-1:0] lvl_old3_q;
	logic [STAMP_W-1:0] stp_new_q;
	logic [STAMP_W-1:0] stp_old_q;

	logic               in_fire;
	logic               cfg_fire;
	logic               out_load;
	logic               wr_en;
	logic [AW-1:0]      next_slot;
	logic [LEVEL_W-1:0] rd_level;
	logic [STAMP_W-1:0] rd_stamp;
	logic               div_done;
	logic [SW-1:0]      div_quo;

	logic [MW-1:0]      cur_lim_m;
	logic [MW-1:0]      new_lim_m;
	logic [CW-1:0]      cur_eff;
	logic [CW-1:0]      new_eff;
	logic [CW-1:0]      held_inc;
	logic [CW-1:0]      held_rec;

	logic signed [LEVEL_W:0] diff;
	logic signed [TREND_W-1:0] trend_nx;
	logic [STAMP_W-1:0]        span_nx;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid || out_ready);
	assign wr_en     = in_fire && (operation == OP_RECORD);
	assign next_slot = (newest_q == LAST_SLOT) ? '0 : newest_q + 1'b1;

	// effective window limit: 0 or above depth means the full store
	assign cur_lim_m = MW'(limit_q);
	assign new_lim_m = MW'(window_limit);
	assign cur_eff = (cur_lim_m == '0 || cur_lim_m > DEPTH_M) ? DEPTH_C : CW'(cur_lim_m);
	assign new_eff = (new_lim_m == '0 || new_lim_m > DEPTH_M) ? DEPTH_C : CW'(new_lim_m);

	assign held_inc = (held_q < DEPTH_C) ? held_q + 1'b1 : held_q;
	assign held_rec = (held_inc > cur_eff) ? cur_eff : held_inc;

	assign diff = $signed({1'b0, lvl_new_q}) - $signed({1'b0, lvl_old3_q});

	always_comb begin
		trend_nx = TREND_FLAT;
		if (held_q >= CW'(TREND_MIN_COUNT)) begin
			if (diff > THR_P) begin
				trend_nx = TREND_UP;
			end else if (diff < THR_N) begin
				trend_nx = TREND_DOWN;
			end
		end
	end

	assign span_nx = (held_q > CW'(1)) ? stp_new_q - stp_old_q : '0;

	wls_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (next_slot),
		.wr_level (level),
		.wr_stamp (stamp),
		.rd_en    (state_q == ST_WALK),
		.rd_addr  (rd_addr_q),
		.rd_level (rd_level),
		.rd_stamp (rd_stamp)
	);

	wls_div #(
		.NW (SW),
		.DW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIV_GO),
		.numer    (sum_q),
		.denom    (held_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			limit_q      <= LIMIT_RESET;
			newest_q     <= '0;
			held_q       <= '0;
			idx_q        <= '0;
			rd_addr_q    <= '0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			out_valid    <= 1'b0;
			sample_count <= '0;
			level_min    <= '0;
			level_max    <= '0;
			level_mean   <= '0;
			span         <= '0;
			trend        <= TREND_FLAT;
		end else begin
			rd_vld_s1 <= (state_q == ST_WALK);
			idx_s1    <= idx_q;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						limit_q <= window_limit;
						if (held_q > new_eff) begin
							held_q <= new_eff;
						end
					end else if (in_fire) begin
						if (operation == OP_CLEAR) begin
							held_q <= '0;
						end else begin
							newest_q <= next_slot;
							held_q   <= held_rec;
						end
						state_q <= ST_START;
					end
				end
				ST_START: begin
					idx_q     <= '0;
					rd_addr_q <= newest_q;
					state_q   <= (held_q == '0) ? ST_FINISH : ST_WALK;
				end
				ST_WALK: begin
					idx_q     <= idx_q + 1'b1;
					rd_addr_q <= (rd_addr_q == '0) ? LAST_SLOT : rd_addr_q - 1'b1;
					if (idx_q == held_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						sample_count <= COUNT_OUT_W'(held_q);
						if (held_q == '0) begin
							level_min  <= '0;
							level_max  <= '0;
							level_mean <= '0;
						end else begin
							level_min  <= min_q;
							level_max  <= max_q;
							level_mean <= div_quo[LEVEL_W-1:0];
						end
						span    <= span_nx;
						trend   <= trend_nx;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// running figures over the ring walk
	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			min_q <= '1;
			max_q <= '0;
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			if (rd_level < min_q) begin
				min_q <= rd_level;
			end
			if (rd_level > max_q) begin
				max_q <= rd_level;
			end
			sum_q <= sum_q + SW'(rd_level);
			if (idx_s1 == '0) begin
				lvl_new_q <= rd_level;
				stp_new_q <= rd_stamp;
			end
			if (idx_s1 == CW'(2)) begin
				lvl_old3_q <= rd_level;
			end
			if (idx_s1 == held_q - 1'b1) begin
				stp_old_q <= rd_stamp;
			end
		end
	end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for windowed_level_statistics_top. Sends record and clear
// transactions, predicts count, min, max, mean, span and trend from a local
// copy of the sample ring, and checks every result in order. Covers the
// window limit settings zero, above depth and shrink, full-store overwrite,
// stamp wraparound, the trend thresholds, random idling on both sides and a
// long output hold.
// ----------------------------------------------------------------------------
module tb;
	import wls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH          = STORE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0] cnt;
		logic [LEVEL_W-1:0]     lo;
		logic [LEVEL_W-1:0]     hi;
		logic [LEVEL_W-1:0]     avg;
		logic [STAMP_W-1:0]     spn;
		logic [TREND_W-1:0]     dir;
	} stats_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [LIMIT_W-1:0]        window_limit;
	logic                      in_valid;
	logic                      in_ready;
	logic                      operation;
	logic [LEVEL_W-1:0]        level;
	logic [STAMP_W-1:0]        stamp;
	logic                      out_valid;
	logic                      out_ready;
	logic [COUNT_OUT_W-1:0]    sample_count;
	logic [LEVEL_W-1:0]        level_min;
	logic [LEVEL_W-1:0]        level_max;
	logic [LEVEL_W-1:0]        level_mean;
	logic [STAMP_W-1:0]        span;
	logic signed [TREND_W-1:0] trend;

	// local copy of the sample ring
	logic [LEVEL_W-1:0] ring_level [DEPTH];
	logic [STAMP_W-1:0] ring_stamp [DEPTH];
	int                 ring_head;
	int                 held;
	logic [LIMIT_W-1:0] lim_reg;

	stats_t stats_due [$];
	stats_t seen_stats;

	int errors;
	int n_items;
	int n_clears;
	int n_cfg;
	int n_results;
	int n_holds;
	int hold_len;
	int stall_run;
	bit quiet;
	logic [LEVEL_W-1:0] last_level;
	logic [STAMP_W-1:0] last_stamp;

	windowed_level_statistics_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_limit (window_limit),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.level        (level),
		.stamp        (stamp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_count (sample_count),
		.level_min    (level_min),
		.level_max    (level_max),
		.level_mean   (level_mean),
		.span         (span),
		.trend        (trend)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int eff_limit();
		if (lim_reg == 0 || lim_reg > DEPTH)
			return DEPTH;
		return int'(lim_reg);
	endfunction

	task automatic predict_stats(input logic op, input logic [LEVEL_W-1:0] lv,
			input logic [STAMP_W-1:0] st);
		stats_t      r;
		int unsigned sum;
		int          slot;
		int          diff;
		int          i;
		r = '0;
		if (op == OP_CLEAR) begin
			held = 0;
		end else begin
			ring_head = (ring_head + 1) % DEPTH;
			ring_level[ring_head] = lv;
			ring_stamp[ring_head] = st;
			if (held < DEPTH)
				held++;
			if (held > eff_limit())
				held = eff_limit();
		end
		if (held > 0) begin
			sum = 0;
			r.lo = '1;
			for (i = 0; i < held; i++) begin
				slot = (ring_head + DEPTH - i) % DEPTH;
				if (ring_level[slot] < r.lo)
					r.lo = ring_level[slot];
				if (ring_level[slot] > r.hi)
					r.hi = ring_level[slot];
				sum += ring_level[slot];
			end
			r.avg = LEVEL_W'(sum / held);
		end
		if (held > 1)
			r.spn = ring_stamp[ring_head] - ring_stamp[(ring_head + DEPTH - held + 1) % DEPTH];
		if (held >= TREND_MIN_COUNT) begin
			diff = int'(ring_level[ring_head]) - int'(ring_level[(ring_head + DEPTH - 2) % DEPTH]);
			if (diff > TREND_THRESHOLD)
				r.dir = TREND_UP;
			else if (diff < -TREND_THRESHOLD)
				r.dir = TREND_DOWN;
			else
				r.dir = TREND_FLAT;
		end
		r.cnt = COUNT_OUT_W'(held);
		stats_due.push_back(r);
	endtask

	task automatic send_item(input logic op, input logic [LEVEL_W-1:0] lv,
			input logic [STAMP_W-1:0] st);
		operation <= op;
		level     <= lv;
		stamp     <= st;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_stats(op, lv, st);
		n_items++;
		if (op == OP_CLEAR)
			n_clears++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (stats_due.size() != 0);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		window_limit <= v;
		cfg_valid    <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		lim_reg = v;
		if (held > eff_limit())
			held = eff_limit();
		n_cfg++;
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] prev);
		int v;
		case ($urandom_range(0, 9))
			0: return LEVEL_W'(32768 + $urandom_range(0, 32767));
			1, 2, 3: begin
				v = int'(prev) + int'($urandom_range(0, 240)) - 120;
				if (v < 0)
					v = 0;
				if (v > 65535)
					v = 65535;
				return LEVEL_W'(v);
			end
			default: return LEVEL_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [STAMP_W-1:0] pick_stamp(input logic [STAMP_W-1:0] prev);
		case ($urandom_range(0, 19))
			0: return $urandom;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 2000);
			default: return prev + $urandom_range(1, 5000);
		endcase
	endfunction

	task automatic test_basic();
		send_item(OP_CLEAR, 16'd0, 32'd0);
		send_item(OP_RECORD, 16'd0, 32'hFFFF_FFF0);
		send_item(OP_RECORD, 16'hFFFF, 32'h0000_0010);
		send_item(OP_RECORD, 16'd32768, 32'h0000_0020);
		send_item(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
		// trend edges: +100 flat, +101 up, -101 down, -100 flat
		send_item(OP_RECORD, 16'd2000, 32'd100);
		send_item(OP_RECORD, 16'd2000, 32'd200);
		send_item(OP_RECORD, 16'd2100, 32'd300);
		send_item(OP_RECORD, 16'd2101, 32'd400);
		send_item(OP_RECORD, 16'd1999, 32'd500);
		send_item(OP_RECORD, 16'd2001, 32'd600);
		send_item(OP_CLEAR, 16'd0, 32'd0);
	endtask

	task automatic test_limits();
		logic [LIMIT_W-1:0] lims [6];
		int k;
		lims = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd65, 7'd127};
		for (k = 0; k < 6; k++) begin
			drain();
			write_limit(lims[k]);
			repeat (2) begin
				last_level = pick_level(last_level);
				last_stamp = pick_stamp(last_stamp);
				send_item(OP_RECORD, last_level, last_stamp);
			end
		end
	endtask

	task automatic test_backpressure();
		drain();
		hold_len = 300;
		repeat (12) begin
			last_level = pick_level(last_level);
			last_stamp = pick_stamp(last_stamp);
			send_item(OP_RECORD, last_level, last_stamp);
		end
	endtask

	task automatic run_phase(input int n, input logic [LIMIT_W-1:0] lim, input int clear_pct);
		logic op;
		drain();
		write_limit(lim);
		repeat (n) begin
			op = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_RECORD;
			last_level = pick_level(last_level);
			last_stamp = pick_stamp(last_stamp);
			send_item(op, last_level, last_stamp);
		end
	endtask

	task automatic test_random();
		logic [LIMIT_W-1:0] lims [9];
		int pcts [9];
		int k;
		lims = '{7'd64, 7'd17, 7'd0, 7'd1, 7'd127, 7'd2, 7'd3, 7'd40, 7'd64};
		pcts = '{0, 3, 2, 5, 1, 5, 5, 3, 2};
		for (k = 0; k < 9; k++) begin
			if (k == 8)
				quiet = 1'b1;
			run_phase(120, lims[k], pcts[k]);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			seen_stats = '{sample_count, level_min, level_max, level_mean, span, trend};
			if (stats_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected transaction cnt=%0d min=%0d max=%0d",
						seen_stats.cnt, seen_stats.lo, seen_stats.hi);
			end else if (seen_stats !== stats_due[0]) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: result %0d exp cnt=%0d min=%0d max=%0d mean=%0d span=%0d trend=%0d",
						n_results, stats_due[0].cnt, stats_due[0].lo, stats_due[0].hi,
						stats_due[0].avg, stats_due[0].spn, $signed(stats_due[0].dir));
					$display("       got cnt=%0d min=%0d max=%0d mean=%0d span=%0d trend=%0d",
						seen_stats.cnt, seen_stats.lo, seen_stats.hi, seen_stats.avg,
						seen_stats.spn, $signed(seen_stats.dir));
				end
				stats_due.delete(0);
			end else begin
				stats_due.delete(0);
			end
		end
	end

	// output side stalls
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				n_holds++;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// watchdog: cycles without any transaction
	initial begin
		stall_run = 0;
		while (stall_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready))
				stall_run = 0;
			else
				stall_run++;
		end
		$display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
		$display("windowed_level_statistics_top verification failed");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		window_limit <= '0;
		in_valid     <= 1'b0;
		operation    <= OP_RECORD;
		level        <= '0;
		stamp        <= '0;
		errors     = 0;
		n_items    = 0;
		n_clears   = 0;
		n_cfg      = 0;
		n_results  = 0;
		n_holds    = 0;
		hold_len   = 0;
		quiet      = 1'b0;
		ring_head  = 0;
		held       = 0;
		lim_reg    = LIMIT_RESET;
		last_level = 16'd1000;
		last_stamp = 32'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic();
		test_limits();
		test_backpressure();
		test_random();

		drain();
		repeat (100) @(posedge clk);
		$display("Run covered %0d transactions (%0d clears), %0d results, %0d limit writes",
			n_items, n_clears, n_results, n_cfg);
		$display("Long output holds: %0d, mismatches: %0d", n_holds, errors);
		if (errors == 0)
			$display("windowed_level_statistics_top verification clean");
		else
			$display("windowed_level_statistics_top verification failed");
		$finish;
	end

endmodule
